// ----- rtl/alfd_pkg.sv -----
`timescale 1ns / 1ps

package alfd_pkg;

  // One received word: a byte and the end-of-write marker
  typedef struct packed {
    logic [7:0] data_byte;
    logic       write_end;
  } in_t;

  // One decoded frame
  typedef struct packed {
    logic       spectrum_frame;
    logic [2:0] audio_mode;
    logic [3:0] level_value;
    logic [3:0] band_zero;
    logic [3:0] band_one;
    logic [3:0] band_two;
    logic [3:0] band_three;
    logic [3:0] band_four;
    logic [3:0] band_five;
    logic [3:0] band_six;
    logic [3:0] band_seven;
  } out_t;

  // Framing state, one-hot
  typedef enum logic [2:0] {
    ST_HUNT     = 3'b001,
    ST_LEVEL    = 3'b010,
    ST_SPECTRUM = 3'b100
  } frame_state_e;

  // Frame lengths in bytes, header included
  localparam logic [4:0] LevelLen    = 5'd6;
  localparam logic [4:0] SpectrumLen = 5'd21;

  // Header: three bytes held in the hunt window plus the closing byte
  localparam logic [23:0] HeaderLevel    = 24'h060000;
  localparam logic [23:0] HeaderSpectrum = 24'h210001;
  localparam logic [7:0]  HeaderTail     = 8'h02;

  // Mode limits
  localparam logic [7:0] LevelModeMin    = 8'd1;
  localparam logic [7:0] LevelModeMax    = 8'd5;
  localparam logic [7:0] SpectrumModeMax = 8'd4;

  // Clamp ceiling for level and bands
  localparam logic [7:0] ClampMax = 8'd12;

  // Payload bytes kept: frame positions 4 through 12
  localparam logic [4:0]  FieldBase  = 5'd4;
  localparam int unsigned FieldCount = 9;

  // Hunt window holds at most three bytes
  localparam logic [1:0] HuntFull = 2'd3;

  function automatic logic [3:0] clamp12(input logic [7:0] v);
    logic [3:0] r;
    r = (v > ClampMax) ? ClampMax[3:0] : v[3:0];
    return r;
  endfunction

endpackage

// ----- rtl/alfd_deframer.sv -----
`timescale 1ns / 1ps

module alfd_deframer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  alfd_pkg::in_t word_i,
  output logic          hit_o,
  output alfd_pkg::out_t result_o
);

  alfd_pkg::frame_state_e state_q, state_d;
  logic [4:0]  fill_q, fill_d;
  logic [23:0] win_q, win_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [7:0]  field_q [alfd_pkg::FieldCount];

  logic [4:0] frame_len;
  logic [4:0] fill_inc;
  logic       done;
  logic       tail_ok;

  // Work out the next framing state
  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    win_d    = win_q;
    hcnt_d   = hcnt_q;
    frame_len = (state_q == alfd_pkg::ST_LEVEL) ? alfd_pkg::LevelLen : alfd_pkg::SpectrumLen;
    fill_inc = fill_q + 5'd1;
    done     = (state_q != alfd_pkg::ST_HUNT) && (fill_inc == frame_len);
    tail_ok  = (hcnt_q == alfd_pkg::HuntFull) && (word_i.data_byte == alfd_pkg::HeaderTail);

    unique case (state_q)
      alfd_pkg::ST_HUNT: begin
        if (tail_ok && (win_q == alfd_pkg::HeaderLevel)) begin
          state_d = alfd_pkg::ST_LEVEL;
          fill_d  = alfd_pkg::FieldBase;
          hcnt_d  = 2'd0;
        end else if (tail_ok && (win_q == alfd_pkg::HeaderSpectrum)) begin
          state_d = alfd_pkg::ST_SPECTRUM;
          fill_d  = alfd_pkg::FieldBase;
          hcnt_d  = 2'd0;
        end else begin
          win_d = {win_q[15:0], word_i.data_byte};
          if (hcnt_q != alfd_pkg::HuntFull) begin
            hcnt_d = hcnt_q + 2'd1;
          end
        end
        // A header never spans two writes
        if (word_i.write_end) begin
          hcnt_d = 2'd0;
        end
      end
      alfd_pkg::ST_LEVEL, alfd_pkg::ST_SPECTRUM: begin
        fill_d = fill_inc;
        if (done) begin
          fill_d = 5'd0;
          // Back to hunting only when the frame closes its write
          if (word_i.write_end) begin
            state_d = alfd_pkg::ST_HUNT;
            hcnt_d  = 2'd0;
          end
        end
      end
      default: begin
        state_d = alfd_pkg::ST_HUNT;
        fill_d  = 5'd0;
      end
    endcase
  end

  // Decode the frame that completes with this word
  always_comb begin
    hit_o    = 1'b0;
    result_o = '0;
    if (state_q == alfd_pkg::ST_LEVEL) begin
      hit_o = done && (word_i.data_byte >= alfd_pkg::LevelModeMin)
                   && (word_i.data_byte <= alfd_pkg::LevelModeMax);
      result_o.audio_mode  = 3'(word_i.data_byte - alfd_pkg::LevelModeMin);
      result_o.level_value = alfd_pkg::clamp12(field_q[0]);
    end else if (state_q == alfd_pkg::ST_SPECTRUM) begin
      hit_o = done && (field_q[0] <= alfd_pkg::SpectrumModeMax);
      result_o.spectrum_frame = 1'b1;
      result_o.audio_mode     = field_q[0][2:0];
      result_o.band_zero      = alfd_pkg::clamp12(field_q[1]);
      result_o.band_one       = alfd_pkg::clamp12(field_q[2]);
      result_o.band_two       = alfd_pkg::clamp12(field_q[3]);
      result_o.band_three     = alfd_pkg::clamp12(field_q[4]);
      result_o.band_four      = alfd_pkg::clamp12(field_q[5]);
      result_o.band_five      = alfd_pkg::clamp12(field_q[6]);
      result_o.band_six       = alfd_pkg::clamp12(field_q[7]);
      result_o.band_seven     = alfd_pkg::clamp12(field_q[8]);
    end
  end

  // Advance framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alfd_pkg::ST_HUNT;
      fill_q  <= 5'd0;
      win_q   <= 24'd0;
      hcnt_q  <= 2'd0;
    end else if (step_i) begin
      state_q <= state_d;
      fill_q  <= fill_d;
      win_q   <= win_d;
      hcnt_q  <= hcnt_d;
    end
  end

  // Capture the payload bytes at their frame positions
  always_ff @(posedge clk_i) begin
    if (step_i && (state_q != alfd_pkg::ST_HUNT)) begin
      for (int i = 0; i < alfd_pkg::FieldCount; i++) begin
        if (fill_q == alfd_pkg::FieldBase + 5'(i)) begin
          field_q[i] <= word_i.data_byte;
        end
      end
    end
  end

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < alfd_pkg::SpectrumLen)
    else $error("fill count past spectrum frame length");

  a_hunt_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == alfd_pkg::ST_HUNT) |-> (fill_q == 5'd0))
    else $error("fill count nonzero while hunting");

  a_level_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == alfd_pkg::ST_LEVEL) |-> (fill_q < alfd_pkg::LevelLen))
    else $error("fill count past level frame length");

  a_hit_framing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> ((state_q != alfd_pkg::ST_HUNT) && (fill_q >= alfd_pkg::FieldBase + 5'd1)))
    else $error("result raised outside a frame");

endmodule

// ----- rtl/audio_level_frame_deframer.sv -----
`timescale 1ns / 1ps

// Audio level frame deframer. Takes one byte word per cycle when not stalled,
// hunts for a level (06 00 00 02) or spectrum (21 00 01 02) header within one
// write, and gives one result word per frame with a valid mode. An accepted
// byte passes through the input register, then the framing and decode logic,
// then the result register. Sustained rate is one byte per cycle; a byte that
// gives no result moves on even while a finished result waits on out_ready_i,
// and only a byte that completes a valid frame waits for the result register
// to free up.
module audio_level_frame_deframer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  alfd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output alfd_pkg::out_t out_data_o
);

  logic           s0_valid_q;
  alfd_pkg::in_t  s0_word_q;
  logic           out_valid_q;
  alfd_pkg::out_t out_word_q;

  logic           hit;
  alfd_pkg::out_t result;
  logic           out_free;
  logic           advance;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = s0_valid_q && (!hit || out_free);
  assign in_ready_o = !s0_valid_q || advance;

  alfd_deframer u_deframer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .word_i   (s0_word_q),
    .hit_o    (hit),
    .result_o (result)
  );

  // Hold the accepted word until the framer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s0_word_q <= in_data_i;
    end
  end

  // Load a result word, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && hit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && hit) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(out_word_q))
    else $error("result word overwritten before taken");

  a_step_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> s0_valid_q)
    else $error("framer stepped without a word");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && !advance) |=> (s0_valid_q && $stable(s0_word_q)))
    else $error("stalled word lost");

endmodule
